// ===== rtl/cmbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP message byte parser package
// Shared types, codes and the option format table of the byte parser.
// ----------------------------------------------------------------------------
package cmbp_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_TOKEN     = 3'd1;
    localparam logic [2:0] KIND_OPT_HEAD  = 3'd2;
    localparam logic [2:0] KIND_OPT_VALUE = 3'd3;
    localparam logic [2:0] KIND_MARKER    = 3'd4;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd5;
    localparam logic [2:0] KIND_DISCARD   = 3'd6;

    // Option value formats.
    localparam logic [1:0] FMT_EMPTY  = 2'd0;
    localparam logic [1:0] FMT_OPAQUE = 2'd1;
    localparam logic [1:0] FMT_UINT   = 2'd2;
    localparam logic [1:0] FMT_STRING = 2'd3;

    // Status codes.
    localparam logic [3:0] STATUS_OK           = 4'd0;
    localparam logic [3:0] STATUS_BAD_VERSION  = 4'd1;
    localparam logic [3:0] STATUS_TOKEN_LONG   = 4'd2;
    localparam logic [3:0] STATUS_NIBBLE_15    = 4'd3;
    localparam logic [3:0] STATUS_TRUNCATED    = 4'd4;
    localparam logic [3:0] STATUS_EMPTY_LENGTH = 4'd5;
    localparam logic [3:0] STATUS_OPTION_LONG  = 4'd6;
    localparam logic [3:0] STATUS_BARE_MARKER  = 4'd7;
    localparam logic [3:0] STATUS_EMPTY_MSG    = 4'd8;

    // Configuration register indexes.
    localparam logic CFG_OPTION_LENGTH_LIMIT = 1'b0;
    localparam logic CFG_TOKEN_LENGTH_LIMIT  = 1'b1;

    // Protocol constants.
    localparam logic [7:0]  PAYLOAD_MARKER = 8'hff;
    localparam logic [3:0]  NIBBLE_EXT8    = 4'd13;
    localparam logic [3:0]  NIBBLE_EXT16   = 4'd14;
    localparam logic [3:0]  NIBBLE_RESV    = 4'd15;
    localparam logic [16:0] EXT8_OFFSET    = 17'd13;
    localparam logic [16:0] EXT16_OFFSET   = 17'd269;
    localparam logic [1:0]  COAP_VERSION   = 2'd1;

    localparam logic [16:0] OPTION_LENGTH_LIMIT_RESET = 17'd1034;
    localparam logic [3:0]  TOKEN_LENGTH_LIMIT_RESET  = 4'd8;

    typedef enum logic [11:0] {
        PH_HDR   = 12'b0000_0000_0001,
        PH_TOK   = 12'b0000_0000_0010,
        PH_HEAD  = 12'b0000_0000_0100,
        PH_D13   = 12'b0000_0000_1000,
        PH_D14A  = 12'b0000_0001_0000,
        PH_D14B  = 12'b0000_0010_0000,
        PH_L13   = 12'b0000_0100_0000,
        PH_L14A  = 12'b0000_1000_0000,
        PH_L14B  = 12'b0001_0000_0000,
        PH_VAL   = 12'b0010_0000_0000,
        PH_PAY   = 12'b0100_0000_0000,
        PH_ERR   = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  byte_out;
        logic        value_end;
        logic [31:0] option_number;
        logic [1:0]  option_format;
        logic [16:0] option_length;
        logic [31:0] uint_value;
        logic [1:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] message_id;
        logic        message_end;
        logic [3:0]  status;
    } result_t;

    // Value format of an option number, after the RFC 7252 option registry.
    function automatic logic [1:0] option_format_of(input logic [31:0] num);
        logic [1:0] f;
        f = FMT_EMPTY;
        if (num inside {32'd1, 32'd4}) begin
            f = FMT_OPAQUE;
        end
        else if (num inside {32'd6, 32'd7, 32'd12, 32'd14, 32'd17, 32'd23, 32'd27,
                             32'd28, 32'd60}) begin
            f = FMT_UINT;
        end
        else if (num inside {32'd3, 32'd8, 32'd11, 32'd15, 32'd20, 32'd35,
                             32'd39}) begin
            f = FMT_STRING;
        end
        return f;
    endfunction

endpackage

// ===== rtl/cmbp_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP message byte parser channels
// Valid/ready channel interfaces for input bytes, results and configuration.
// ----------------------------------------------------------------------------
interface cmbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface cmbp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  byte_out;
    logic        value_end;
    logic [31:0] option_number;
    logic [1:0]  option_format;
    logic [16:0] option_length;
    logic [31:0] uint_value;
    logic [1:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] message_id;
    logic        message_end;
    logic [3:0]  status;

    modport source (
        output valid, output kind, output byte_out, output value_end,
        output option_number, output option_format, output option_length,
        output uint_value, output msg_type, output msg_code, output message_id,
        output message_end, output status, input ready
    );
    modport sink (
        input valid, input kind, input byte_out, input value_end,
        input option_number, input option_format, input option_length,
        input uint_value, input msg_type, input msg_code, input message_id,
        input message_end, input status, output ready
    );
endinterface

interface cmbp_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [16:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/cmbp_out_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP parser result buffer
// Two-entry output register with skid stage for the result channel.
// ----------------------------------------------------------------------------
module cmbp_out_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cmbp_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output cmbp_pkg::result_t out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    cmbp_pkg::result_t out_data_reg;
    cmbp_pkg::result_t skid_data_reg;
    logic              out_load;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = out_ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_valid && !skid_valid_reg)
        begin
            skid_data_reg <= in_data;
        end
    end

endmodule

// ===== rtl/coap_message_byte_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP message byte parser
// Parses a CoAP datagram one byte at a time and reports one result per byte.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transaction carries
//  -------  ---------  ---------------------------------------------------
//  in_ch    sink       one datagram byte and its last-byte flag
//  out_ch   source     one parse result for each accepted byte
//  cfg_ch   sink       one write to a limit register (index, data)
//
// The parse state and the result are computed in a single pass from the
// state registers and the incoming byte, and the result is registered into
// a two-entry output buffer. A byte is accepted in every cycle while the
// buffer's skid entry is free, so the input only stalls once the result side
// has held off with both entries full. Reset clears the parse state and
// loads the limit registers with their defaults; the parse state also
// returns to its reset value after each byte flagged last.
// ----------------------------------------------------------------------------
module coap_message_byte_parser (
    input  logic  clk,
    input  logic  rst_n,
    cmbp_in_if.sink    in_ch,
    cmbp_out_if.source out_ch,
    cmbp_cfg_if.sink   cfg_ch
);

    // Configuration registers.
    logic [16:0] opt_len_limit_reg;
    logic [3:0]  tok_len_limit_reg;

    // Parse state.
    cmbp_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [1:0]  msg_type_reg, msg_type_next;
    logic [7:0]  msg_code_reg, msg_code_next;
    logic [15:0] message_id_reg, message_id_next;
    logic [3:0]  tok_rem_reg, tok_rem_next;
    logic        tok_seen_reg, tok_seen_next;
    logic [31:0] opt_num_reg, opt_num_next;
    logic [3:0]  len_nib_reg, len_nib_next;
    logic [7:0]  ext_hi_reg, ext_hi_next;
    logic [16:0] opt_len_reg, opt_len_next;
    logic [16:0] val_rem_reg, val_rem_next;
    logic [31:0] uint_acc_reg, uint_acc_next;
    logic        marker_reg, marker_next;
    logic [3:0]  err_reg, err_next;

    // Per-byte working signals.
    logic [7:0]  b;
    logic [2:0]  kind;
    logic        end_flag;
    logic        head_done;
    logic [3:0]  raise;
    logic        fin_delta;
    logic        fin_len;
    logic [16:0] delta_val;
    logic [16:0] len_val;
    logic [3:0]  len_nib;
    logic [1:0]  fmt;
    logic [3:0]  status;
    logic        in_accept;
    logic        skid_ready;
    cmbp_pkg::result_t result;
    cmbp_pkg::result_t out_data;

    assign b         = in_ch.data_byte;
    assign in_ch.ready = skid_ready;
    assign in_accept = in_ch.valid && skid_ready;
    assign cfg_ch.ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration writes. Both limits are taken at any time; the user
    // writes them only between datagrams.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opt_len_limit_reg <= cmbp_pkg::OPTION_LENGTH_LIMIT_RESET;
            tok_len_limit_reg <= cmbp_pkg::TOKEN_LENGTH_LIMIT_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                cmbp_pkg::CFG_OPTION_LENGTH_LIMIT: opt_len_limit_reg <= cfg_ch.data;
                cmbp_pkg::CFG_TOKEN_LENGTH_LIMIT:  tok_len_limit_reg <= cfg_ch.data[3:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Byte decode. The option delta is added to the running option number
    // first; the format of the resulting number then decides whether the
    // decoded length is legal.
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        msg_type_next   = msg_type_reg;
        msg_code_next   = msg_code_reg;
        message_id_next = message_id_reg;
        tok_rem_next    = tok_rem_reg;
        tok_seen_next   = tok_seen_reg;
        opt_num_next    = opt_num_reg;
        len_nib_next    = len_nib_reg;
        ext_hi_next     = ext_hi_reg;
        opt_len_next    = opt_len_reg;
        val_rem_next    = val_rem_reg;
        uint_acc_next   = uint_acc_reg;
        marker_next     = marker_reg;
        kind            = cmbp_pkg::KIND_DISCARD;
        end_flag        = 1'b0;
        head_done       = 1'b0;
        raise           = cmbp_pkg::STATUS_OK;
        fin_delta       = 1'b0;
        fin_len         = 1'b0;
        delta_val       = 17'd0;
        len_val         = 17'd0;
        len_nib         = len_nib_reg;

        case (phase_reg)
            cmbp_pkg::PH_HDR:
            begin
                kind = cmbp_pkg::KIND_HEADER;
                case (hdr_cnt_reg)
                    2'd0:
                    begin
                        msg_type_next   = b[5:4];
                        msg_code_next   = 8'd0;
                        message_id_next = 16'd0;
                        tok_rem_next    = b[3:0];
                        tok_seen_next   = (b[3:0] != 4'd0);
                        hdr_cnt_next    = 2'd1;
                        if (b[7:6] != cmbp_pkg::COAP_VERSION)
                        begin
                            raise = cmbp_pkg::STATUS_BAD_VERSION;
                        end
                        else if (b[3:0] > tok_len_limit_reg)
                        begin
                            raise = cmbp_pkg::STATUS_TOKEN_LONG;
                        end
                    end
                    2'd1:
                    begin
                        msg_code_next = b;
                        hdr_cnt_next  = 2'd2;
                    end
                    2'd2:
                    begin
                        message_id_next[15:8] = b;
                        hdr_cnt_next          = 2'd3;
                    end
                    default:
                    begin
                        message_id_next[7:0] = b;
                        hdr_cnt_next         = 2'd0;
                        phase_next = (tok_rem_reg != 4'd0) ? cmbp_pkg::PH_TOK
                                                           : cmbp_pkg::PH_HEAD;
                    end
                endcase
            end
            cmbp_pkg::PH_TOK:
            begin
                kind         = cmbp_pkg::KIND_TOKEN;
                tok_rem_next = tok_rem_reg - 4'd1;
                if (tok_rem_next == 4'd0)
                begin
                    end_flag   = 1'b1;
                    phase_next = cmbp_pkg::PH_HEAD;
                end
            end
            cmbp_pkg::PH_HEAD:
            begin
                if (b == cmbp_pkg::PAYLOAD_MARKER)
                begin
                    kind        = cmbp_pkg::KIND_MARKER;
                    marker_next = 1'b1;
                    phase_next  = cmbp_pkg::PH_PAY;
                end
                else
                begin
                    kind          = cmbp_pkg::KIND_OPT_HEAD;
                    uint_acc_next = 32'd0;
                    len_nib_next  = b[3:0];
                    len_nib       = b[3:0];
                    if (b[7:4] == cmbp_pkg::NIBBLE_RESV || b[3:0] == cmbp_pkg::NIBBLE_RESV)
                    begin
                        raise = cmbp_pkg::STATUS_NIBBLE_15;
                    end
                    else if (b[7:4] == cmbp_pkg::NIBBLE_EXT8)
                    begin
                        phase_next = cmbp_pkg::PH_D13;
                    end
                    else if (b[7:4] == cmbp_pkg::NIBBLE_EXT16)
                    begin
                        phase_next = cmbp_pkg::PH_D14A;
                    end
                    else
                    begin
                        fin_delta = 1'b1;
                        delta_val = {13'd0, b[7:4]};
                    end
                end
            end
            cmbp_pkg::PH_D13:
            begin
                kind      = cmbp_pkg::KIND_OPT_HEAD;
                fin_delta = 1'b1;
                delta_val = cmbp_pkg::EXT8_OFFSET + {9'd0, b};
            end
            cmbp_pkg::PH_D14A:
            begin
                kind        = cmbp_pkg::KIND_OPT_HEAD;
                ext_hi_next = b;
                phase_next  = cmbp_pkg::PH_D14B;
            end
            cmbp_pkg::PH_D14B:
            begin
                kind      = cmbp_pkg::KIND_OPT_HEAD;
                fin_delta = 1'b1;
                delta_val = cmbp_pkg::EXT16_OFFSET + {1'b0, ext_hi_reg, b};
            end
            cmbp_pkg::PH_L13:
            begin
                kind    = cmbp_pkg::KIND_OPT_HEAD;
                fin_len = 1'b1;
                len_val = cmbp_pkg::EXT8_OFFSET + {9'd0, b};
            end
            cmbp_pkg::PH_L14A:
            begin
                kind        = cmbp_pkg::KIND_OPT_HEAD;
                ext_hi_next = b;
                phase_next  = cmbp_pkg::PH_L14B;
            end
            cmbp_pkg::PH_L14B:
            begin
                kind    = cmbp_pkg::KIND_OPT_HEAD;
                fin_len = 1'b1;
                len_val = cmbp_pkg::EXT16_OFFSET + {1'b0, ext_hi_reg, b};
            end
            cmbp_pkg::PH_VAL:
            begin
                kind      = cmbp_pkg::KIND_OPT_VALUE;
                head_done = 1'b1;
                if (cmbp_pkg::option_format_of(opt_num_reg) == cmbp_pkg::FMT_UINT)
                begin
                    uint_acc_next = {uint_acc_reg[23:0], b};
                end
                val_rem_next = val_rem_reg - 17'd1;
                if (val_rem_next == 17'd0)
                begin
                    end_flag   = 1'b1;
                    phase_next = cmbp_pkg::PH_HEAD;
                end
            end
            cmbp_pkg::PH_PAY:
            begin
                kind = cmbp_pkg::KIND_PAYLOAD;
            end
            default:
            begin
                kind = cmbp_pkg::KIND_DISCARD;
            end
        endcase

        // The delta is complete: move the option number on, then either
        // wait for a length extension or settle the length from the nibble.
        if (fin_delta)
        begin
            opt_num_next = opt_num_reg + {15'd0, delta_val};
            if (len_nib == cmbp_pkg::NIBBLE_EXT8)
            begin
                phase_next = cmbp_pkg::PH_L13;
            end
            else if (len_nib == cmbp_pkg::NIBBLE_EXT16)
            begin
                phase_next = cmbp_pkg::PH_L14A;
            end
            else
            begin
                fin_len = 1'b1;
                len_val = {13'd0, len_nib};
            end
        end

        fmt = cmbp_pkg::option_format_of(opt_num_next);

        // The length is complete: check it against the option's format.
        if (fin_len)
        begin
            opt_len_next = len_val;
            head_done    = 1'b1;
            if (fmt == cmbp_pkg::FMT_EMPTY && len_val != 17'd0)
            begin
                raise = cmbp_pkg::STATUS_EMPTY_LENGTH;
            end
            else if ((fmt == cmbp_pkg::FMT_OPAQUE || fmt == cmbp_pkg::FMT_STRING) &&
                     len_val > opt_len_limit_reg)
            begin
                raise = cmbp_pkg::STATUS_OPTION_LONG;
            end
            else if (len_val == 17'd0)
            begin
                end_flag   = 1'b1;
                phase_next = cmbp_pkg::PH_HEAD;
            end
            else
            begin
                val_rem_next = len_val;
                phase_next   = cmbp_pkg::PH_VAL;
            end
        end

        // Any error moves to the discard phase; only the first one is kept.
        err_next = err_reg;
        if (raise != cmbp_pkg::STATUS_OK)
        begin
            phase_next = cmbp_pkg::PH_ERR;
            if (err_reg == cmbp_pkg::STATUS_OK)
            begin
                err_next = raise;
            end
        end

        // Final checks on the last byte of the datagram.
        status = err_next;
        if (in_ch.last && status == cmbp_pkg::STATUS_OK)
        begin
            if (phase_next != cmbp_pkg::PH_HEAD && phase_next != cmbp_pkg::PH_PAY)
            begin
                status = cmbp_pkg::STATUS_TRUNCATED;
            end
            else if (kind == cmbp_pkg::KIND_MARKER)
            begin
                status = cmbp_pkg::STATUS_BARE_MARKER;
            end
            else if (msg_code_next == 8'd0 &&
                     (tok_seen_next || (marker_next && kind == cmbp_pkg::KIND_PAYLOAD)))
            begin
                status = cmbp_pkg::STATUS_EMPTY_MSG;
            end
        end

        result.kind          = kind;
        result.byte_out      = b;
        result.value_end     = end_flag;
        result.option_number = 32'd0;
        result.option_format = cmbp_pkg::FMT_EMPTY;
        result.option_length = 17'd0;
        result.uint_value    = 32'd0;
        if (kind == cmbp_pkg::KIND_OPT_HEAD || kind == cmbp_pkg::KIND_OPT_VALUE)
        begin
            result.option_number = opt_num_next;
            result.option_format = fmt;
            result.option_length = head_done ? opt_len_next : 17'd0;
            result.uint_value    = (fmt == cmbp_pkg::FMT_UINT) ? uint_acc_next : 32'd0;
        end
        result.msg_type    = msg_type_next;
        result.msg_code    = msg_code_next;
        result.message_id  = message_id_next;
        result.message_end = in_ch.last;
        result.status      = status;
    end

    // ------------------------------------------------------------------
    // Parse state. The byte flagged last returns everything to reset.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= cmbp_pkg::PH_HDR;
            hdr_cnt_reg    <= 2'd0;
            msg_type_reg   <= 2'd0;
            msg_code_reg   <= 8'd0;
            message_id_reg <= 16'd0;
            tok_rem_reg    <= 4'd0;
            tok_seen_reg   <= 1'b0;
            opt_num_reg    <= 32'd0;
            len_nib_reg    <= 4'd0;
            ext_hi_reg     <= 8'd0;
            opt_len_reg    <= 17'd0;
            val_rem_reg    <= 17'd0;
            uint_acc_reg   <= 32'd0;
            marker_reg     <= 1'b0;
            err_reg        <= cmbp_pkg::STATUS_OK;
        end
        else if (in_accept)
        begin
            if (in_ch.last)
            begin
                phase_reg      <= cmbp_pkg::PH_HDR;
                hdr_cnt_reg    <= 2'd0;
                msg_type_reg   <= 2'd0;
                msg_code_reg   <= 8'd0;
                message_id_reg <= 16'd0;
                tok_rem_reg    <= 4'd0;
                tok_seen_reg   <= 1'b0;
                opt_num_reg    <= 32'd0;
                len_nib_reg    <= 4'd0;
                ext_hi_reg     <= 8'd0;
                opt_len_reg    <= 17'd0;
                val_rem_reg    <= 17'd0;
                uint_acc_reg   <= 32'd0;
                marker_reg     <= 1'b0;
                err_reg        <= cmbp_pkg::STATUS_OK;
            end
            else
            begin
                phase_reg      <= phase_next;
                hdr_cnt_reg    <= hdr_cnt_next;
                msg_type_reg   <= msg_type_next;
                msg_code_reg   <= msg_code_next;
                message_id_reg <= message_id_next;
                tok_rem_reg    <= tok_rem_next;
                tok_seen_reg   <= tok_seen_next;
                opt_num_reg    <= opt_num_next;
                len_nib_reg    <= len_nib_next;
                ext_hi_reg     <= ext_hi_next;
                opt_len_reg    <= opt_len_next;
                val_rem_reg    <= val_rem_next;
                uint_acc_reg   <= uint_acc_next;
                marker_reg     <= marker_next;
                err_reg        <= err_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result buffer: holds a finished result while the next byte is parsed.
    // ------------------------------------------------------------------
    cmbp_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (skid_ready),
        .in_data   (result),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.kind          = out_data.kind;
    assign out_ch.byte_out      = out_data.byte_out;
    assign out_ch.value_end     = out_data.value_end;
    assign out_ch.option_number = out_data.option_number;
    assign out_ch.option_format = out_data.option_format;
    assign out_ch.option_length = out_data.option_length;
    assign out_ch.uint_value    = out_data.uint_value;
    assign out_ch.msg_type      = out_data.msg_type;
    assign out_ch.msg_code      = out_data.msg_code;
    assign out_ch.message_id    = out_data.message_id;
    assign out_ch.message_end   = out_data.message_end;
    assign out_ch.status        = out_data.status;

endmodule

// ===== rtl/cmbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CoAP parser port checker
// Concurrent assertions on the result channel of the byte parser.
// ----------------------------------------------------------------------------
module cmbp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  byte_out,
    input logic [31:0] option_number,
    input logic [31:0] uint_value,
    input logic        message_end,
    input logic [3:0]  status
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(kind) && $stable(byte_out) && $stable(status))
        else $error("result changed while stalled");

    // Discarded bytes only follow a latched error.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == cmbp_pkg::KIND_DISCARD |-> status != cmbp_pkg::STATUS_OK)
        else $error("discarded byte without an error");

    // A marker that ends the datagram has no payload after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end && kind == cmbp_pkg::KIND_MARKER
        |-> status == cmbp_pkg::STATUS_BARE_MARKER)
        else $error("final marker not reported");

    // Option fields are zero outside option bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != cmbp_pkg::KIND_OPT_HEAD && kind != cmbp_pkg::KIND_OPT_VALUE
        |-> option_number == 32'd0 && uint_value == 32'd0)
        else $error("option fields set outside an option");

endmodule

bind coap_message_byte_parser cmbp_checker u_cmbp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .kind          (out_ch.kind),
    .byte_out      (out_ch.byte_out),
    .option_number (out_ch.option_number),
    .uint_value    (out_ch.uint_value),
    .message_end   (out_ch.message_end),
    .status        (out_ch.status)
);
